### hdl/gsaf_pkg.sv
`timescale 1ns / 1ps

package gsaf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int POS_BITS    = 33;
  localparam int GAIN_BITS   = 16;
  localparam int STEP_BITS   = 24;
  localparam int OPEN_BITS   = 15;
  localparam int MUL_BITS    = SAMPLE_BITS + 1;
  localparam int KP_BITS     = POS_BITS + 4;
  localparam int FR_BITS     = KP_BITS + 2;

  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GATE_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OPEN_LEVEL     = 1'b1;

  localparam logic signed [SAMPLE_BITS-1:0] THRESHOLD_RESET = 16'sd33;
  localparam logic [OPEN_BITS-1:0]          OPEN_LEVEL_RESET = 15'd32767;
  localparam logic signed [SAMPLE_BITS-1:0] NORMAL_HIGH      = 16'sd3277;
  localparam logic [GAIN_BITS-1:0]          UNITY            = 16'd32768;
  localparam logic [POS_BITS-1:0]           POS_ONE          = 33'h1_0000_0000;

  localparam logic [POS_BITS-1:0] SEG_EDGE0 = 33'd858993459;
  localparam logic [POS_BITS-1:0] SEG_EDGE1 = 33'd1288490189;
  localparam logic [POS_BITS-1:0] SEG_EDGE2 = 33'd3006477107;
  localparam logic [POS_BITS-1:0] SEG_EDGE3 = 33'd3435973837;

  // intercepts in Q.35 with the half-LSB rounding term of the Q1.15 gain folded in
  localparam logic signed [FR_BITS-1:0] SEG_BIAS0 = 39'sd34360262656;
  localparam logic signed [FR_BITS-1:0] SEG_BIAS1 = 39'sd38655229952;
  localparam logic signed [FR_BITS-1:0] SEG_BIAS2 = 39'sd51540131840;
  localparam logic signed [FR_BITS-1:0] SEG_BIAS3 = 39'sd9449452339;
  localparam logic signed [FR_BITS-1:0] SEG_BIAS4 = 39'sd12885426176;
  localparam logic signed [FR_BITS-1:0] FR_LOW    = 39'sd524288;
  localparam logic signed [FR_BITS-1:0] FR_HIGH   = 39'sd34360262656;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_FIN  = 2'd1,
    MODE_ON   = 2'd2,
    MODE_FOUT = 2'd3
  } fade_mode_t;

  typedef enum logic [2:0] {
    GS_KEEP,
    GS_ZERO,
    GS_UNITY,
    GS_CURVE,
    GS_CURVE_INV
  } gain_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CURVE,
    ST_MUL_L,
    ST_MUL_R,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [2:0]                    channel;
    logic signed [SAMPLE_BITS-1:0] trigger_sample;
    logic                          trigger_connected;
    logic                          button_click;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic                          left_connected;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          right_connected;
    logic [STEP_BITS-1:0]          fade_in_step;
    logic [STEP_BITS-1:0]          fade_out_step;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                    out_channel;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [GAIN_BITS-1:0]          fade_gain;
    logic [1:0]                    fade_mode;
    logic                          button_lit;
  } out_item_t;

  typedef struct packed {
    fade_mode_t           mode;
    logic [POS_BITS-1:0]  pos;
    logic [GAIN_BITS-1:0] gain;
    logic                 btn;
  } chan_state_t;

  function automatic logic [2:0] seg_index(logic [POS_BITS-1:0] pos);
    logic [2:0] seg;
    seg = 3'd0;
    if (pos >= SEG_EDGE0) seg = 3'd1;
    if (pos >= SEG_EDGE1) seg = 3'd2;
    if (pos >= SEG_EDGE2) seg = 3'd3;
    if (pos >= SEG_EDGE3) seg = 3'd4;
    return seg;
  endfunction

  function automatic logic [KP_BITS-1:0] seg_kp(logic [2:0] seg, logic [POS_BITS-1:0] pos);
    logic [KP_BITS-1:0] p1;
    logic [KP_BITS-1:0] p2;
    logic [KP_BITS-1:0] kp;
    p1 = {3'b000, pos, 1'b0};
    p2 = {2'b00, pos, 2'b00};
    case (seg)
      3'd0:    kp = {4'b0000, pos};
      3'd1:    kp = p1 + p2;
      3'd2:    kp = {pos, 4'b0000};
      3'd3:    kp = p1;
      default: kp = p1 + {4'b0000, pos};
    endcase
    return kp;
  endfunction

  function automatic logic signed [FR_BITS-1:0] seg_bias(logic [2:0] seg);
    logic signed [FR_BITS-1:0] b;
    case (seg)
      3'd0:    b = SEG_BIAS0;
      3'd1:    b = SEG_BIAS1;
      3'd2:    b = SEG_BIAS2;
      3'd3:    b = SEG_BIAS3;
      default: b = SEG_BIAS4;
    endcase
    return b;
  endfunction

endpackage

### hdl/gsaf_store.sv
`timescale 1ns / 1ps

module gsaf_store #(
  parameter int CHANNELS = 8
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       rd_en,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
  output gsaf_pkg::chan_state_t                      rd_data,
  input  logic                                       wr_en,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_addr,
  input  gsaf_pkg::chan_state_t                      wr_data
);
  import gsaf_pkg::*;

  chan_state_t         mem [CHANNELS];
  logic [CHANNELS-1:0] valid_r;
  chan_state_t         rd_data_r;
  logic                rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

### hdl/gsaf_mul.sv
`timescale 1ns / 1ps

module gsaf_mul (
  input  logic                                         clk,
  input  logic                                         go,
  input  logic signed [gsaf_pkg::MUL_BITS-1:0]         op_a,
  input  logic signed [gsaf_pkg::MUL_BITS-1:0]         op_b,
  output logic signed [gsaf_pkg::SAMPLE_BITS-1:0]      result
);
  import gsaf_pkg::*;

  localparam int PROD_BITS = 2 * MUL_BITS;
  localparam int SHIFT     = GAIN_BITS - 1;

  logic signed [PROD_BITS-1:0] prod_r;
  logic signed [PROD_BITS-1:0] rounded;

  always_ff @(posedge clk) begin
    if (go) begin
      prod_r <= op_a * op_b;
    end
  end

  // round half up, then floor shift
  assign rounded = prod_r + (PROD_BITS'(1) <<< (SHIFT - 1));
  assign result  = rounded[SHIFT +: SAMPLE_BITS];

endmodule

### hdl/gated_stereo_auto_fader.sv
`timescale 1ns / 1ps

// Eight-channel gated stereo auto-fader.
// Input channel (in_valid/in_ready/in_data): one sample of one fader channel
// with its gate, button click, stereo pair and fade rates. Result channel
// (out_valid/out_ready/out_data): one item per input, carrying the channel,
// both faded samples, the gain, the fade mode and the button lamp.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 gate threshold, 1 open level) at a clock edge; write only while idle.
// Steps: an item runs through these steps in order, and the next item is
// accepted only once the last is done: one state read, one decision step,
// one curve step, two passes through the shared 17x17 multiplier (left,
// then right), one write-back/output load. The per-channel state memory
// is read and written once per item.
// Reset (rst_n low, synchronous): all channels off with zero position, gain
// and button; registers return to threshold 33 and open level 32767.
// A stalled receiver holds the result in the output register; the block
// still takes one more item and finishes it, then waits before writing back.
module gated_stereo_auto_fader #(
  parameter int CHANNELS = 8
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  gsaf_pkg::in_item_t                        in_data,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output gsaf_pkg::out_item_t                       out_data,
  input  logic                                      cfg_we,
  input  logic [gsaf_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [gsaf_pkg::CFG_DATA_BITS-1:0]        cfg_wdata
);
  import gsaf_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

  function automatic logic [2:0] wrap_channel(logic [2:0] c);
    logic [6:0] r;
    r = {4'b0000, c};
    for (int i = 0; i < 8; i++) begin
      if (r >= CH_LIMIT) r = r - CH_LIMIT;
    end
    return r[2:0];
  endfunction

  seq_state_t state_r, state_nxt;
  logic       mul_go;
  logic       out_load;

  logic signed [SAMPLE_BITS-1:0] thr_r;
  logic [OPEN_BITS-1:0]          open_r;

  in_item_t             in_r;
  logic [2:0]           ch_r;
  logic [2:0]           in_ch;
  chan_state_t          cur;
  chan_state_t          wb;
  fade_mode_t           mode_r, mode_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic                 btn_r, btn_nxt;
  gain_sel_t            gsel_r, gsel_nxt;
  logic [2:0]           seg_r;
  logic [KP_BITS-1:0]   kp_r;
  logic [GAIN_BITS-1:0] old_gain_r;
  logic [GAIN_BITS-1:0] gain_r, gain_nxt;

  logic                          btn1;
  logic signed [SAMPLE_BITS-1:0] level;
  logic                          gate;
  logic [POS_BITS-1:0]           pos_fin, pos_fout, pos_mirror;
  logic signed [FR_BITS-1:0]     fr;
  logic [GAIN_BITS-1:0]          curve_gain;

  logic signed [MUL_BITS-1:0]    op_a, op_b;
  logic signed [SAMPLE_BITS-1:0] mul_result;
  logic signed [SAMPLE_BITS-1:0] left_r;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    mul_go    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL:  state_nxt = ST_CURVE;
      ST_CURVE: state_nxt = ST_MUL_L;
      ST_MUL_L: begin
        mul_go    = 1'b1;
        state_nxt = ST_MUL_R;
      end
      ST_MUL_R: begin
        mul_go    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RESET;
      open_r <= OPEN_LEVEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GATE_THRESHOLD: thr_r  <= cfg_wdata;
        CFG_OPEN_LEVEL:     open_r <= cfg_wdata[OPEN_BITS-1:0];
        default:            ;
      endcase
    end
  end

  assign in_ch = wrap_channel(in_data.channel);

  gsaf_store #(
    .CHANNELS(CHANNELS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_valid && in_ready),
    .rd_addr (CH_W'(in_ch)),
    .rd_data (cur),
    .wr_en   (out_load),
    .wr_addr (CH_W'(ch_r)),
    .wr_data (wb)
  );

  // decision step
  always_comb begin
    btn1 = cur.btn ^ in_r.button_click;
    if (in_r.trigger_connected) begin
      level = in_r.trigger_sample;
    end else if (cur.mode == MODE_FIN || cur.mode == MODE_ON) begin
      level = NORMAL_HIGH;
    end else begin
      level = '0;
    end
    gate       = level >= thr_r;
    pos_fin    = cur.pos + {{(POS_BITS-STEP_BITS){1'b0}}, in_r.fade_in_step};
    pos_fout   = cur.pos + {{(POS_BITS-STEP_BITS){1'b0}}, in_r.fade_out_step};
    pos_mirror = POS_ONE - cur.pos;

    mode_nxt = cur.mode;
    pos_nxt  = cur.pos;
    btn_nxt  = btn1;
    gsel_nxt = GS_KEEP;
    case (cur.mode)
      MODE_FOUT: begin
        if (gate || btn1) begin
          btn_nxt  = 1'b1;
          pos_nxt  = pos_mirror;
          mode_nxt = MODE_FIN;
        end else begin
          pos_nxt  = pos_fout;
          gsel_nxt = GS_CURVE;
          if (pos_fout >= POS_ONE) begin
            gsel_nxt = GS_ZERO;
            mode_nxt = MODE_OFF;
          end
        end
      end
      MODE_OFF: begin
        if (gate || btn1) begin
          btn_nxt  = 1'b1;
          mode_nxt = MODE_FIN;
          pos_nxt  = '0;
        end else begin
          gsel_nxt = GS_ZERO;
        end
      end
      MODE_FIN: begin
        if (!gate || !btn1) begin
          btn_nxt  = 1'b0;
          pos_nxt  = pos_mirror;
          mode_nxt = MODE_FOUT;
        end else begin
          pos_nxt  = pos_fin;
          gsel_nxt = GS_CURVE_INV;
          if (pos_fin >= POS_ONE) begin
            gsel_nxt = GS_UNITY;
            mode_nxt = MODE_ON;
          end
        end
      end
      default: begin
        if (!gate || !btn1) begin
          btn_nxt  = 1'b0;
          mode_nxt = MODE_FOUT;
          pos_nxt  = '0;
        end else begin
          gsel_nxt = GS_UNITY;
        end
      end
    endcase
  end

  // curve step: f = b - k*p, clamped, rounded to Q1.15
  always_comb begin
    fr = seg_bias(seg_r) - $signed({2'b00, kp_r});
    if (fr < FR_LOW) begin
      curve_gain = '0;
    end else if (fr > FR_HIGH) begin
      curve_gain = UNITY;
    end else begin
      curve_gain = fr[20 +: GAIN_BITS];
    end
    case (gsel_r)
      GS_ZERO:      gain_nxt = '0;
      GS_UNITY:     gain_nxt = UNITY;
      GS_CURVE:     gain_nxt = curve_gain;
      GS_CURVE_INV: gain_nxt = UNITY - curve_gain;
      default:      gain_nxt = old_gain_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
      ch_r <= in_ch;
    end
    if (state_r == ST_EVAL) begin
      mode_r     <= mode_nxt;
      pos_r      <= pos_nxt;
      btn_r      <= btn_nxt;
      gsel_r     <= gsel_nxt;
      seg_r      <= seg_index(cur.pos);
      kp_r       <= seg_kp(seg_index(cur.pos), cur.pos);
      old_gain_r <= cur.gain;
    end
    if (state_r == ST_CURVE) begin
      gain_r <= gain_nxt;
    end
    if (state_r == ST_MUL_R) begin
      left_r <= mul_result;
    end
  end

  // shared multiplier: left pass, then right pass
  always_comb begin
    if (state_r == ST_MUL_L) begin
      op_a = in_r.left_connected ? {in_r.left_sample[SAMPLE_BITS-1], in_r.left_sample}
                                 : {2'b00, open_r};
    end else begin
      op_a = in_r.right_connected ? {in_r.right_sample[SAMPLE_BITS-1], in_r.right_sample}
                                  : {2'b00, open_r};
    end
    op_b = {1'b0, gain_r};
  end

  gsaf_mul u_mul (
    .clk    (clk),
    .go     (mul_go),
    .op_a   (op_a),
    .op_b   (op_b),
    .result (mul_result)
  );

  assign wb.mode = mode_r;
  assign wb.pos  = pos_r;
  assign wb.gain = gain_r;
  assign wb.btn  = btn_r;

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.out_channel <= ch_r;
      out_data_r.left_out    <= left_r;
      out_data_r.right_out   <= mul_result;
      out_data_r.fade_gain   <= gain_r;
      out_data_r.fade_mode   <= mode_r;
      out_data_r.button_lit  <= btn_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result loaded outside write-back step");

  a_lamp_follows_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.button_lit ==
      (out_data_r.fade_mode == MODE_FIN || out_data_r.fade_mode == MODE_ON))
    else $error("button lamp disagrees with fade mode");

  a_gain_at_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.fade_gain <= UNITY) &&
      (out_data_r.fade_mode != MODE_ON || out_data_r.fade_gain == UNITY) &&
      (out_data_r.fade_mode != MODE_OFF || out_data_r.fade_gain == '0))
    else $error("gain out of range for fade mode");

endmodule
